// ===== hdl/trag_pkg.sv =====
// Package for the tile-to-raster address generator.
// Register map, configuration and pipeline item types shared by all modules.
// No dependencies.
`default_nettype none

package trag_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BW_W       = 16;
    localparam int unsigned BH_W       = 14;
    localparam int unsigned BLK_W      = 14;
    localparam int unsigned IMG_W      = 24;
    localparam int unsigned BAND_W     = 16;
    localparam int unsigned OFFSET_W   = 48;
    localparam int unsigned COL_W      = 30;
    localparam int unsigned ROW_W      = 28;
    localparam int unsigned PROD_W     = ROW_W + IMG_W;

    typedef enum logic [2:0] {
        REG_BLOCK_WIDTH  = 3'd0,
        REG_BLOCK_HEIGHT = 3'd1,
        REG_BLOCKS_ACROSS = 3'd2,
        REG_BLOCKS_DOWN  = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5,
        REG_BAND_COUNT   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [BW_W-1:0]   block_width;
        logic [BH_W-1:0]   block_height;
        logic [BLK_W-1:0]  blocks_across;
        logic [BLK_W-1:0]  blocks_down;
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
        logic [BAND_W-1:0] band_count;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              overrun;
        logic              done;
        logic [BAND_W-1:0] band;
        logic [BW_W-1:0]   byte_in_row;
        logic [BH_W-1:0]   row_in_block;
        logic [BLK_W-1:0]  block_col;
        logic [BLK_W-1:0]  block_row;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   pixel_byte;
        logic                keep;
        logic [OFFSET_W-1:0] band_offset;
        logic [BAND_W-1:0]   band_index;
        logic                image_done;
        logic                overrun;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/trag_cfg.sv =====
// Configuration register bank for the tile-to-raster address generator.
// APB-style write and read port; depends on trag_pkg.
`default_nettype none

module trag_cfg
    import trag_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_BLOCK_WIDTH:   cfg_next.block_width   = pwdata[BW_W-1:0];
                REG_BLOCK_HEIGHT:  cfg_next.block_height  = pwdata[BH_W-1:0];
                REG_BLOCKS_ACROSS: cfg_next.blocks_across = pwdata[BLK_W-1:0];
                REG_BLOCKS_DOWN:   cfg_next.blocks_down   = pwdata[BLK_W-1:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[IMG_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = pwdata[IMG_W-1:0];
                REG_BAND_COUNT:    cfg_next.band_count    = pwdata[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_BLOCK_WIDTH:   prdata = CFG_DATA_W'(cfg_reg.block_width);
            REG_BLOCK_HEIGHT:  prdata = CFG_DATA_W'(cfg_reg.block_height);
            REG_BLOCKS_ACROSS: prdata = CFG_DATA_W'(cfg_reg.blocks_across);
            REG_BLOCKS_DOWN:   prdata = CFG_DATA_W'(cfg_reg.blocks_down);
            REG_IMAGE_WIDTH:   prdata = CFG_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:  prdata = CFG_DATA_W'(cfg_reg.image_height);
            REG_BAND_COUNT:    prdata = CFG_DATA_W'(cfg_reg.band_count);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_width   <= BW_W'(1);
            cfg_reg.block_height  <= BH_W'(1);
            cfg_reg.blocks_across <= BLK_W'(1);
            cfg_reg.blocks_down   <= BLK_W'(1);
            cfg_reg.image_width   <= IMG_W'(1);
            cfg_reg.image_height  <= IMG_W'(1);
            cfg_reg.band_count    <= BAND_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/trag_offset_pipe.sv =====
// Offset pipeline: column and row products, raster offset product, crop compare.
// Four register stages moving together; depends on trag_pkg.
`default_nettype none

module trag_offset_pipe
    import trag_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output res_t       out_res
);

    logic  adv;

    logic  v1_reg, v2_reg, v3_reg, vo_reg;
    item_t s1_reg;

    logic [BYTE_W-1:0] s2_byte_reg;
    logic              s2_ovr_reg;
    logic              s2_done_reg;
    logic [BAND_W-1:0] s2_band_reg;
    logic [COL_W-1:0]  s2_col_reg;
    logic [ROW_W-1:0]  s2_row_reg;

    logic [BYTE_W-1:0]   s3_byte_reg;
    logic                s3_ovr_reg;
    logic                s3_done_reg;
    logic [BAND_W-1:0]   s3_band_reg;
    logic                s3_keep_reg;
    logic [COL_W-1:0]    s3_col_reg;
    logic [OFFSET_W-1:0] s3_prod_reg;

    res_t res_reg;
    res_t res_next;

    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [PROD_W-1:0] prod_full;
    logic              keep_next;

    assign adv       = !vo_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = vo_reg;
    assign out_res   = res_reg;

    assign col_next  = COL_W'(s1_reg.block_col) * COL_W'(cfg.block_width)
                       + COL_W'(s1_reg.byte_in_row);
    assign row_next  = ROW_W'(s1_reg.block_row) * ROW_W'(cfg.block_height)
                       + ROW_W'(s1_reg.row_in_block);

    assign keep_next = !s2_ovr_reg
                       && (s2_col_reg < COL_W'(cfg.image_width))
                       && (s2_row_reg < ROW_W'(cfg.image_height));
    assign prod_full = PROD_W'(s2_row_reg) * PROD_W'(cfg.image_width);

    always_comb begin
        res_next.pixel_byte  = s3_byte_reg;
        res_next.keep        = s3_keep_reg;
        res_next.band_offset = s3_keep_reg
                               ? OFFSET_W'(s3_prod_reg + OFFSET_W'(s3_col_reg)) : '0;
        res_next.band_index  = s3_ovr_reg ? '0 : s3_band_reg;
        res_next.image_done  = s3_done_reg;
        res_next.overrun     = s3_ovr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg      <= in_item;

            s2_byte_reg <= s1_reg.data_byte;
            s2_ovr_reg  <= s1_reg.overrun;
            s2_done_reg <= s1_reg.done;
            s2_band_reg <= s1_reg.band;
            s2_col_reg  <= col_next;
            s2_row_reg  <= row_next;

            s3_byte_reg <= s2_byte_reg;
            s3_ovr_reg  <= s2_ovr_reg;
            s3_done_reg <= s2_done_reg;
            s3_band_reg <= s2_band_reg;
            s3_keep_reg <= keep_next;
            s3_col_reg  <= s2_col_reg;
            s3_prod_reg <= prod_full[OFFSET_W-1:0];

            res_reg     <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tile_to_raster_address_gen_core.sv =====
// Top level of the tile-to-raster address generator.
// Block counters and beat handshakes; depends on trag_pkg, trag_cfg and trag_offset_pipe.
//
// Usage:
//   s_axis: one beat per byte of the blocked image in file order, s_tdata[7:0].
//   m_axis: one beat per input beat, in order. m_tdata carries the byte,
//   its raster offset within its band and the band index; m_tuser carries
//   keep and overrun; m_tlast marks the final byte of the final band.
//   APB port: seven size registers at byte addresses 0 to 24, written while
//   no beat is in flight; a write does not clear the block counters.
// Throughput: one beat per cycle when not stalled; the four stages of
//   the offset pipeline (capture, column/row products, raster product,
//   final add) all move together, so one byte leaves for every byte taken.
// Stall: while a result waits in the output register with m_tready low, the
//   whole pipeline holds and s_tready is low.
// Reset: all counters clear, the finished latch clears, the pipeline
//   empties and every size register returns to one.
`default_nettype none

module tile_to_raster_address_gen_core
    import trag_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [71:0]           m_tdata,   // [7:0] pixel_byte, [55:8] band_offset,
                                                  // [71:56] band_index
    output logic      [1:0]            m_tuser,   // [0] keep, [1] overrun
    output logic                       m_tlast,   // image_done

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t  cfg;
    item_t item;
    res_t  res;
    logic  s_accept;
    logic  ovr;
    logic  done;

    logic [BW_W-1:0]   bib_reg,  bib_next;
    logic [BH_W-1:0]   rib_reg,  rib_next;
    logic [BLK_W-1:0]  bcol_reg, bcol_next;
    logic [BLK_W-1:0]  brow_reg, brow_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              finished_reg, finished_next;

    logic wrap_byte, wrap_row, wrap_col, wrap_brow;

    trag_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_accept  = s_tvalid && s_tready;
    assign ovr       = finished_reg || (band_reg >= cfg.band_count);

    assign wrap_byte = ({1'b0, bib_reg}  + (BW_W+1)'(1))  >= {1'b0, cfg.block_width};
    assign wrap_row  = ({1'b0, rib_reg}  + (BH_W+1)'(1))  >= {1'b0, cfg.block_height};
    assign wrap_col  = ({1'b0, bcol_reg} + (BLK_W+1)'(1)) >= {1'b0, cfg.blocks_across};
    assign wrap_brow = ({1'b0, brow_reg} + (BLK_W+1)'(1)) >= {1'b0, cfg.blocks_down};

    always_comb begin
        bib_next      = bib_reg;
        rib_next      = rib_reg;
        bcol_next     = bcol_reg;
        brow_next     = brow_reg;
        band_next     = band_reg;
        finished_next = finished_reg;
        done          = 1'b0;
        if (s_accept && !ovr) begin
            if (!wrap_byte) begin
                bib_next = bib_reg + BW_W'(1);
            end else begin
                bib_next = '0;
                if (!wrap_row) begin
                    rib_next = rib_reg + BH_W'(1);
                end else begin
                    rib_next = '0;
                    if (!wrap_col) begin
                        bcol_next = bcol_reg + BLK_W'(1);
                    end else begin
                        bcol_next = '0;
                        if (!wrap_brow) begin
                            brow_next = brow_reg + BLK_W'(1);
                        end else begin
                            brow_next = '0;
                            band_next = band_reg + BAND_W'(1);
                            if ((band_next >= cfg.band_count) || (band_next == '0)) begin
                                done          = 1'b1;
                                finished_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bib_reg      <= '0;
            rib_reg      <= '0;
            bcol_reg     <= '0;
            brow_reg     <= '0;
            band_reg     <= '0;
            finished_reg <= 1'b0;
        end else begin
            bib_reg      <= bib_next;
            rib_reg      <= rib_next;
            bcol_reg     <= bcol_next;
            brow_reg     <= brow_next;
            band_reg     <= band_next;
            finished_reg <= finished_next;
        end
    end

    always_comb begin
        item.data_byte    = s_tdata;
        item.overrun      = ovr;
        item.done         = done;
        item.band         = band_reg;
        item.byte_in_row  = bib_reg;
        item.row_in_block = rib_reg;
        item.block_col    = bcol_reg;
        item.block_row    = brow_reg;
    end

    trag_offset_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_accept),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.band_index, res.band_offset, res.pixel_byte};
    assign m_tuser = {res.overrun, res.keep};
    assign m_tlast = res.image_done;

    a_overrun_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && !m_tlast && (m_tdata[71:8] == '0))
        else $error("overrun beat carries keep, offset, band or done");

    a_finished_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |=> finished_reg)
        else $error("finished latch dropped without reset");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off while output free");

    a_no_count_on_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && ovr |=> $stable(band_reg) && $stable(bib_reg))
        else $error("counters moved on an overrun beat");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for tile_to_raster_address_gen_core: drives byte beats in,
// predicts each result from its own copy of the counters and registers, and checks
// every output beat in order. Depends on trag_pkg and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trag_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic        aclk;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // [7:0] pixel_byte, [55:8] band_offset, [71:56] band_index
    logic [1:0]  m_tuser;          // [0] keep, [1] overrun
    logic        m_tlast;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tile_to_raster_address_gen_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // register shadow
    logic [15:0] cfg_bw = 16'd1;
    logic [13:0] cfg_bh = 14'd1;
    logic [13:0] cfg_ba = 14'd1;
    logic [13:0] cfg_bd = 14'd1;
    logic [23:0] cfg_iw = 24'd1;
    logic [23:0] cfg_ih = 24'd1;
    logic [15:0] cfg_bands = 16'd1;

    // counter shadow
    logic [15:0] byte_ctr = '0;
    logic [13:0] row_ctr = '0;
    logic [13:0] col_ctr = '0;
    logic [13:0] brow_ctr = '0;
    logic [15:0] band_ctr = '0;
    logic        img_finished = 1'b0;

    res_t        pending_results[$];

    int src_idle = 32;
    int sink_idle = 32;
    int hold_req = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    int n_sent = 0;
    int n_checked = 0;
    int n_mismatch = 0;
    int n_cfg = 0;
    int n_done = 0;
    int n_overrun = 0;
    int n_pad = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] next_count(input logic [31:0] c, input logic [31:0] lim,
                                               output logic wrapped);
        wrapped = (c + 32'd1 >= lim);
        return wrapped ? 32'd0 : c + 32'd1;
    endfunction

    function automatic res_t predict_beat(input logic [7:0] b);
        res_t        r;
        logic [63:0] col;
        logic [63:0] row;
        logic [63:0] prod;
        logic        w;
        r = '0;
        r.pixel_byte = b;
        if (img_finished || band_ctr >= cfg_bands) begin
            r.overrun = 1'b1;
            return r;
        end
        col = 64'(col_ctr);
        col = col * cfg_bw + byte_ctr;
        row = 64'(brow_ctr);
        row = row * cfg_bh + row_ctr;
        r.keep = (col < cfg_iw) && (row < cfg_ih);
        if (r.keep) begin
            prod = row * cfg_iw + col;
            r.band_offset = prod[47:0];
        end
        r.band_index = band_ctr;
        byte_ctr = 16'(next_count(32'(byte_ctr), 32'(cfg_bw), w));
        if (w) row_ctr = 14'(next_count(32'(row_ctr), 32'(cfg_bh), w));
        if (w) col_ctr = 14'(next_count(32'(col_ctr), 32'(cfg_ba), w));
        if (w) brow_ctr = 14'(next_count(32'(brow_ctr), 32'(cfg_bd), w));
        if (w) begin
            band_ctr = band_ctr + 16'd1;
            if (band_ctr >= cfg_bands || band_ctr == 16'd0) begin
                r.image_done = 1'b1;
                img_finished = 1'b1;
            end
        end
        return r;
    endfunction

    // all tasks start and end on a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_beat(b));
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_BLOCK_WIDTH:   cfg_bw = val[15:0];
            REG_BLOCK_HEIGHT:  cfg_bh = val[13:0];
            REG_BLOCKS_ACROSS: cfg_ba = val[13:0];
            REG_BLOCKS_DOWN:   cfg_bd = val[13:0];
            REG_IMAGE_WIDTH:   cfg_iw = val[23:0];
            REG_IMAGE_HEIGHT:  cfg_ih = val[23:0];
            REG_BAND_COUNT:    cfg_bands = val[15:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_geometry(input int unsigned bw, input int unsigned bh,
                                input int unsigned ba, input int unsigned bd,
                                input int unsigned iw, input int unsigned ih,
                                input int unsigned bands);
        wait_results();
        apb_write(REG_BLOCK_WIDTH, bw);
        apb_write(REG_BLOCK_HEIGHT, bh);
        apb_write(REG_BLOCKS_ACROSS, ba);
        apb_write(REG_BLOCKS_DOWN, bd);
        apb_write(REG_IMAGE_WIDTH, iw);
        apb_write(REG_IMAGE_HEIGHT, ih);
        apb_write(REG_BAND_COUNT, bands);
    endtask

    // one full band of 3x2 blocks, 2 across and 2 down, with right and bottom padding
    task automatic test_block_walk();
        logic [7:0] pattern[4];
        pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        set_geometry(3, 2, 2, 2, 5, 3, 65535);
        for (int i = 0; i < 24; i++)
            send_byte(i < 4 ? pattern[i] : 8'($urandom_range(255)));
    endtask

    task automatic test_zero_sizes();
        set_geometry(0, 0, 3, 0, 2, 1, 65535);
        repeat (8) send_byte(8'($urandom_range(255)));
        wait_results();
        apb_write(REG_IMAGE_WIDTH, 0);
        repeat (3) send_byte(8'($urandom_range(255)));
    endtask

    // bands exhausted without the image completing: overrun, no latch
    task automatic test_band_overrun();
        wait_results();
        apb_write(REG_BAND_COUNT, 0);
        repeat (4) send_byte(8'($urandom_range(255)));
        wait_results();
        apb_write(REG_BAND_COUNT, 32'(band_ctr));
        repeat (3) send_byte(8'($urandom_range(255)));
        wait_results();
        apb_write(REG_BAND_COUNT, 65535);
        repeat (3) send_byte(8'($urandom_range(255)));
    endtask

    // grow block_row and block_column, then widen the blocks for large offsets
    task automatic test_large_offsets();
        set_geometry(1, 1, 1, 9999, 16777215, 16777215, 65535);
        repeat (120) send_byte(8'($urandom_range(255)));
        wait_results();
        apb_write(REG_BLOCKS_ACROSS, 9999);
        repeat (80) send_byte(8'($urandom_range(255)));
        wait_results();
        apb_write(REG_BLOCK_WIDTH, 65535);
        apb_write(REG_BLOCK_HEIGHT, 8192);
        repeat (60) send_byte(8'($urandom_range(255)));
        wait_results();
        apb_write(REG_IMAGE_WIDTH, 1000);
        apb_write(REG_IMAGE_HEIGHT, 5000);
        repeat (20) send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_random_geometry();
        int unsigned bw, bh, ba, bd, iw, ih;
        for (int p = 0; p < 10; p++) begin
            bw = $urandom_range(6, 1);
            bh = $urandom_range(4, 1);
            ba = $urandom_range(4, 1);
            bd = $urandom_range(3, 1);
            iw = $urandom_range(bw * ba + 2, 1);
            ih = $urandom_range(bh * bd + 2, 1);
            if ($urandom_range(15) == 0) bw = 0;
            if ($urandom_range(15) == 0) bh = 0;
            if ($urandom_range(15) == 0) ba = 0;
            if ($urandom_range(15) == 0) bd = 0;
            if ($urandom_range(15) == 0) iw = 0;
            if ($urandom_range(15) == 0) ih = 0;
            if ($urandom_range(7) == 0) iw = 16777215;
            if ($urandom_range(7) == 0) ih = 16777215;
            set_geometry(bw, bh, ba, bd, iw, ih, $urandom_range(65535, 4000));
            src_idle = (p == 2) ? 0 : 32;
            sink_idle = (p == 2) ? 0 : 32;
            for (int i = 0; i < 130; i++) begin
                if (p == 4 && i == 20) hold_req = 300;
                if (p == 6 && i == 75) wait_results();
                send_byte(8'($urandom_range(255)));
            end
        end
        src_idle = 32;
        sink_idle = 32;
    endtask

    // complete the last band, then check the finished latch holds
    task automatic test_image_done();
        set_geometry(1, 1, 1, 1, 1, 1, 65535);
        send_byte(8'($urandom_range(255)));
        set_geometry(2, 2, 2, 2, 3, 3, band_ctr + 2);
        repeat (40) send_byte(8'($urandom_range(255)));
        wait_results();
        apb_write(REG_BAND_COUNT, 65535);
        repeat (10) send_byte(8'($urandom_range(255)));
    endtask

    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge aclk) begin
        res_t exp_r;
        res_t got;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         stall_cycles, pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.pixel_byte  = m_tdata[7:0];
                got.band_offset = m_tdata[55:8];
                got.band_index  = m_tdata[71:56];
                got.keep        = m_tuser[0];
                got.overrun     = m_tuser[1];
                got.image_done  = m_tlast;
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result beat: byte %h offset %0d band %0d",
                                 got.pixel_byte, got.band_offset, got.band_index);
                end else begin
                    exp_r = pending_results.pop_front();
                    n_checked++;
                    if (exp_r.image_done) n_done++;
                    if (exp_r.overrun) n_overrun++;
                    else if (!exp_r.keep) n_pad++;
                    if (got.pixel_byte !== exp_r.pixel_byte || got.keep !== exp_r.keep ||
                        got.band_offset !== exp_r.band_offset ||
                        got.band_index !== exp_r.band_index ||
                        got.image_done !== exp_r.image_done ||
                        got.overrun !== exp_r.overrun) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("result %0d mismatch at %0t", n_checked, $realtime);
                            $display("  exp: byte %h keep %b offset %0d band %0d done %b ovr %b",
                                     exp_r.pixel_byte, exp_r.keep, exp_r.band_offset,
                                     exp_r.band_index, exp_r.image_done, exp_r.overrun);
                            $display("  got: byte %h keep %b offset %0d band %0d done %b ovr %b",
                                     got.pixel_byte, got.keep, got.band_offset,
                                     got.band_index, got.image_done, got.overrun);
                        end
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_block_walk();
        test_zero_sizes();
        test_band_overrun();
        test_large_offsets();
        test_random_geometry();
        test_image_done();
        wait_results();
        repeat (10) @(negedge aclk);
        if (pending_results.size() != 0) begin
            n_mismatch++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("covered %0d beats in, %0d results checked, %0d register writes",
                 n_sent, n_checked, n_cfg);
        $display("padding %0d, overrun %0d, image done %0d, mismatches %0d",
                 n_pad, n_overrun, n_done, n_mismatch);
        if (n_mismatch == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/trag_pkg.sv
hdl/trag_cfg.sv
hdl/trag_offset_pipe.sv
hdl/tile_to_raster_address_gen_core.sv
tb/tb.sv
